FILE: rtl/core/tcce_pkg.sv
package tcce_pkg;

    localparam int COLS       = 80;
    localparam int ROWS       = 25;
    localparam int LINE_MAX   = 500;
    localparam int CELL_COUNT = ROWS * COLS;

    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLS);
    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int LC_W   = $clog2(LINE_MAX);

    // queue depth must be a power of two (pointers wrap naturally)
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } item_t;

    typedef struct packed {
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
        logic [7:0] cell_char;
        logic       line_done;
        logic [8:0] line_length;
    } result_t;

    typedef enum logic [2:0] {
        OP_PRINT,
        OP_NEWLINE,
        OP_BACKSPACE,
        OP_READ,
        OP_CLEAR,
        OP_NOP
    } op_kind_t;

    typedef struct packed {
        op_kind_t         kind;
        logic [7:0]       char_code;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } op_t;

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_SWEEP
    } back_state_t;

endpackage

FILE: rtl/core/tcce_ram.sv
module tcce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        q_reg <= mem[raddr];
    end

    assign q = q_reg;

endmodule

FILE: rtl/core/tcce_front.sv
module tcce_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  tcce_pkg::item_t item,
    input  logic            q_full,
    output logic            busy,
    output logic            push,
    output tcce_pkg::op_t   push_word
);

    logic          valid_reg, valid_next;
    tcce_pkg::op_t word_reg, word_next;
    logic          accept;

    assign busy   = valid_reg && q_full;
    assign accept = start && !busy;
    assign push   = valid_reg && !q_full;
    assign push_word = word_reg;

    // classify the command; an out-of-range read behaves as a no-op
    always_comb
    begin
        word_next           = word_reg;
        if (accept)
        begin
            word_next.char_code = item.char_code;
            word_next.row       = tcce_pkg::ROW_W'(item.read_row);
            word_next.col       = tcce_pkg::COL_W'(item.read_col);
            case (item.command)
                tcce_pkg::CMD_PUT:
                begin
                    if (item.char_code == tcce_pkg::CH_NEWLINE)
                        word_next.kind = tcce_pkg::OP_NEWLINE;
                    else if (item.char_code == tcce_pkg::CH_BACKSPACE)
                        word_next.kind = tcce_pkg::OP_BACKSPACE;
                    else
                        word_next.kind = tcce_pkg::OP_PRINT;
                end
                tcce_pkg::CMD_READ:
                begin
                    if (int'(item.read_row) < tcce_pkg::ROWS &&
                        int'(item.read_col) < tcce_pkg::COLS)
                        word_next.kind = tcce_pkg::OP_READ;
                    else
                        word_next.kind = tcce_pkg::OP_NOP;
                end
                tcce_pkg::CMD_CLEAR: word_next.kind = tcce_pkg::OP_CLEAR;
                default:             word_next.kind = tcce_pkg::OP_NOP;
            endcase
        end
    end

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (push)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

endmodule

FILE: rtl/core/tcce_queue.sv
module tcce_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tcce_pkg::op_t push_word,
    input  logic          pop,
    output logic          full,
    output logic          empty,
    output tcce_pkg::op_t head
);

    tcce_pkg::op_t                 slot_reg [tcce_pkg::Q_DEPTH];
    logic [tcce_pkg::QPTR_W-1:0]   wptr_reg, wptr_next;
    logic [tcce_pkg::QPTR_W-1:0]   rptr_reg, rptr_next;
    logic [tcce_pkg::QCNT_W-1:0]   cnt_reg, cnt_next;

    assign full  = (int'(cnt_reg) == tcce_pkg::Q_DEPTH);
    assign empty = (cnt_reg == '0);
    assign head  = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = pop  ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_word;
        end
    end

endmodule

FILE: rtl/core/tcce_back.sv
module tcce_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  tcce_pkg::op_t     head,
    output logic              pop,
    output logic              done,
    output tcce_pkg::result_t result
);

    localparam int ROW_W  = tcce_pkg::ROW_W;
    localparam int COL_W  = tcce_pkg::COL_W;
    localparam int ADDR_W = tcce_pkg::ADDR_W;
    localparam int LC_W   = tcce_pkg::LC_W;

    tcce_pkg::back_state_t state_reg, state_next;

    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [LC_W-1:0]   lc_reg, lc_next;
    logic [ROW_W-1:0]  base_reg, base_next;
    logic [ADDR_W-1:0] sweep_addr_reg, sweep_addr_next;
    logic [ADDR_W-1:0] sweep_end_reg, sweep_end_next;
    logic              emit_reg, emit_next;
    tcce_pkg::result_t res_reg, res_next;
    logic              done_reg, done_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [ADDR_W-1:0] cell_addr;
    logic [7:0]        ram_q;

    logic              take;
    logic              at_last_row;
    logic              at_last_col;
    logic              scroll;
    logic              sweep_last;
    logic [ROW_W-1:0]  bs_row;
    logic [COL_W-1:0]  bs_col;
    logic [ROW_W-1:0]  a_row;
    logic [COL_W-1:0]  a_col;
    logic [ROW_W:0]    row_sum;
    logic [ROW_W-1:0]  prow;
    logic [ADDR_W-1:0] base_addr;
    logic [ROW_W-1:0]  base_inc;

    tcce_ram #(
        .WIDTH (8),
        .DEPTH (tcce_pkg::CELL_COUNT)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cell_addr),
        .q     (ram_q)
    );

    assign take        = (state_reg == tcce_pkg::S_IDLE) && !q_empty;
    assign at_last_row = (int'(row_reg) == tcce_pkg::ROWS - 1);
    assign at_last_col = (int'(col_reg) == tcce_pkg::COLS - 1);
    assign sweep_last  = (sweep_addr_reg == sweep_end_reg);

    // rows are kept in a ring: logical row r sits at physical (r + base) % ROWS
    always_comb
    begin
        scroll = 1'b0;
        if (take && at_last_row)
        begin
            if (head.kind == tcce_pkg::OP_NEWLINE)
                scroll = 1'b1;
            else if (head.kind == tcce_pkg::OP_PRINT && at_last_col)
                scroll = 1'b1;
        end
    end

    always_comb
    begin
        bs_row = (col_reg == '0) ? row_reg - 1'b1 : row_reg;
        bs_col = (col_reg == '0) ? COL_W'(tcce_pkg::COLS - 1) : col_reg - 1'b1;
        case (head.kind)
            tcce_pkg::OP_READ:
            begin
                a_row = head.row;
                a_col = head.col;
            end
            tcce_pkg::OP_BACKSPACE:
            begin
                a_row = bs_row;
                a_col = bs_col;
            end
            default:
            begin
                a_row = row_reg;
                a_col = col_reg;
            end
        endcase
        row_sum   = {1'b0, a_row} + {1'b0, base_reg};
        prow      = (int'(row_sum) >= tcce_pkg::ROWS) ?
                    ROW_W'(int'(row_sum) - tcce_pkg::ROWS) : row_sum[ROW_W-1:0];
        cell_addr = ADDR_W'(int'(prow) * tcce_pkg::COLS + int'(a_col));
        base_addr = ADDR_W'(int'(base_reg) * tcce_pkg::COLS);
        base_inc  = (int'(base_reg) == tcce_pkg::ROWS - 1) ? '0 : base_reg + 1'b1;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tcce_pkg::S_INIT,
            tcce_pkg::S_SWEEP:
            begin
                if (sweep_last)
                    state_next = tcce_pkg::S_IDLE;
            end
            tcce_pkg::S_READ: state_next = tcce_pkg::S_IDLE;
            tcce_pkg::S_IDLE:
            begin
                if (take)
                begin
                    if (head.kind == tcce_pkg::OP_READ)
                        state_next = tcce_pkg::S_READ;
                    else if (head.kind == tcce_pkg::OP_CLEAR || scroll)
                        state_next = tcce_pkg::S_SWEEP;
                end
            end
            default: state_next = tcce_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        row_next        = row_reg;
        col_next        = col_reg;
        lc_next         = lc_reg;
        base_next       = base_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_end_next  = sweep_end_reg;
        emit_next       = emit_reg;
        res_next        = res_reg;
        done_next       = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = cell_addr;
        ram_wdata       = tcce_pkg::CH_SPACE;
        pop             = take;

        case (state_reg)
            tcce_pkg::S_INIT,
            tcce_pkg::S_SWEEP:
            begin
                ram_we          = 1'b1;
                ram_waddr       = sweep_addr_reg;
                sweep_addr_next = sweep_addr_reg + 1'b1;
                if (sweep_last && emit_reg)
                    done_next = 1'b1;
            end
            tcce_pkg::S_READ:
            begin
                res_next.cell_char = ram_q;
                done_next          = 1'b1;
            end
            tcce_pkg::S_IDLE:
            begin
                if (take)
                begin
                    case (head.kind)
                        tcce_pkg::OP_PRINT:
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = head.char_code;
                            if (int'(lc_reg) < tcce_pkg::LINE_MAX - 1)
                                lc_next = lc_reg + 1'b1;
                            if (at_last_col)
                            begin
                                col_next = '0;
                                if (!at_last_row)
                                    row_next = row_reg + 1'b1;
                            end
                            else
                                col_next = col_reg + 1'b1;
                        end
                        tcce_pkg::OP_NEWLINE:
                        begin
                            lc_next  = '0;
                            col_next = '0;
                            if (!at_last_row)
                                row_next = row_reg + 1'b1;
                        end
                        tcce_pkg::OP_BACKSPACE:
                        begin
                            if (row_reg != '0 || col_reg != '0)
                            begin
                                ram_we   = 1'b1;
                                row_next = bs_row;
                                col_next = bs_col;
                                if (lc_reg != '0)
                                    lc_next = lc_reg - 1'b1;
                            end
                        end
                        tcce_pkg::OP_CLEAR:
                        begin
                            row_next        = '0;
                            col_next        = '0;
                            base_next       = '0;
                            sweep_addr_next = '0;
                            sweep_end_next  = ADDR_W'(tcce_pkg::CELL_COUNT - 1);
                            emit_next       = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase

                    // old top row becomes the new bottom row; blank it
                    if (scroll)
                    begin
                        base_next       = base_inc;
                        sweep_addr_next = base_addr;
                        sweep_end_next  = ADDR_W'(int'(base_addr) + tcce_pkg::COLS - 1);
                        emit_next       = 1'b1;
                    end

                    res_next.cursor_row = 5'(row_next);
                    res_next.cursor_col = 7'(col_next);
                    res_next.cell_char  = '0;
                    res_next.line_done  = (head.kind == tcce_pkg::OP_NEWLINE);
                    res_next.line_length = (head.kind == tcce_pkg::OP_NEWLINE) ?
                                           9'(lc_reg) : 9'(lc_next);
                    done_next = !(head.kind == tcce_pkg::OP_READ ||
                                  head.kind == tcce_pkg::OP_CLEAR || scroll);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tcce_pkg::S_INIT;
            row_reg        <= '0;
            col_reg        <= '0;
            lc_reg         <= '0;
            base_reg       <= '0;
            sweep_addr_reg <= '0;
            sweep_end_reg  <= ADDR_W'(tcce_pkg::CELL_COUNT - 1);
            emit_reg       <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            lc_reg         <= lc_next;
            base_reg       <= base_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_end_reg  <= sweep_end_next;
            emit_reg       <= emit_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

FILE: rtl/core/text_console_char_engine_unit.sv
// channel   | handshake                  | payload
// ----------+----------------------------+------------------------------
// command   | start, taken when !busy    | item   (tcce_pkg::item_t)
// result    | done, one-cycle strobe     | result (tcce_pkg::result_t)
//
// Print, newline and backspace finish in the execution stage from idle; a read
// adds a state for the registered cell RAM read, a scroll sweeps one row of the
// ring to spaces, a clear sweeps all ROWS*COLS cells. After reset the cell RAM
// is swept to spaces, all ROWS*COLS cells; commands queue meanwhile. busy rises
// only while the decode stage holds a word and the 2-entry queue is full; the
// result side has no stall.
module text_console_char_engine_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tcce_pkg::item_t   item,
    output logic              done,
    output tcce_pkg::result_t result
);

    logic          q_full;
    logic          q_empty;
    logic          push;
    logic          pop;
    tcce_pkg::op_t push_word;
    tcce_pkg::op_t head;

    tcce_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .q_full    (q_full),
        .busy      (busy),
        .push      (push),
        .push_word (push_word)
    );

    tcce_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (head)
    );

    tcce_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .head    (head),
        .pop     (pop),
        .done    (done),
        .result  (result)
    );

endmodule

FILE: rtl/core/tcce_checker.sv
module tcce_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input tcce_pkg::item_t   item,
    input logic              done,
    input tcce_pkg::result_t result
);

    logic [2:0] open_reg, open_next;
    logic       accept;

    assign accept = start && !busy;

    always_comb
    begin
        open_next = open_reg;
        if (accept && !done)
            open_next = open_reg + 1'b1;
        else if (done && !accept)
            open_next = open_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_next;
        end
    end

    // no result word without a command still in flight
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> open_reg != 3'd0)
        else $error("result word with no open command");

    // decode stage, queue and execution stage hold at most four words
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg <= 3'd4)
        else $error("more words in flight than storage allows");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (int'(result.cursor_row) < tcce_pkg::ROWS &&
                  int'(result.cursor_col) < tcce_pkg::COLS &&
                  int'(result.line_length) < tcce_pkg::LINE_MAX))
        else $error("cursor or line length out of range");

    a_newline_home: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.line_done) |-> (result.cursor_col == 7'd0 &&
                                        result.cell_char == 8'd0))
        else $error("line done without cursor at column zero");

endmodule

bind text_console_char_engine_unit tcce_checker u_tcce_checker (.*);
